// ===== rtl/core/fch_pkg.sv =====
// Shared widths and constants for the feedback comb high-pass filter.
`default_nettype none
package fch_pkg;

    localparam int FCH_DELAY     = 10;
    localparam int SAMPLE_W      = 16;
    localparam int GAIN_W        = 8;
    localparam int PROD_W        = SAMPLE_W + GAIN_W;   // k * y_old, signed
    localparam int ACC_W         = PROD_W + 1;          // x - k * y_old, signed
    localparam int MAG_W         = ACC_W - 2;           // |acc| < 2^23
    localparam int DIVR_W        = GAIN_W + 1;          // k + 1
    localparam int QUO_W         = 16;                  // |quotient| <= 32768

    localparam logic [QUO_W-2:0] SAT_MAG = 15'h7fff;

endpackage
`default_nettype wire

// ===== rtl/core/fch_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
`default_nettype none
module fch_div
    import fch_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MAG_W-1:0]  i_dividend,
    input  wire logic [DIVR_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [QUO_W-1:0]       o_quotient
);

    logic [DIVR_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0]  r_dvd;
    logic [QUO_W-1:0]  r_quo;
    logic [3:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVR_W:0]   w_trial;
    logic              w_ge;

    // the quotient never exceeds 16 bits, so the top dividend bits are below the divisor
    always_comb begin
        w_trial = {r_rem, r_dvd[QUO_W-1]};
        w_ge    = w_trial >= {1'b0, i_divisor};
        n_rem   = w_ge ? DIVR_W'(w_trial - {1'b0, i_divisor}) : DIVR_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIVR_W'(i_dividend[MAG_W-1:QUO_W]);
            r_dvd <= i_dividend[QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== rtl/core/feedback_comb_highpass.sv =====
// Feedback comb high-pass filter: y = sat((x - k*y[n-DELAY]) / (k+1)).
// One item at a time: o_s_axis_tready is high only in S_IDLE, and each item runs the
// 8-step bit-serial multiply, S_SUB, S_ABS, the 16-step restoring divider and S_FIN;
// a result still waiting on i_m_axis_tready holds the next one back in S_FIN, and the
// output register lets the next item in.
// Reset (sync, active low): gain 0, delay line reads as zero until it fills once.
`default_nettype none
module feedback_comb_highpass
    import fch_pkg::*;
#(
    parameter int DELAY = FCH_DELAY
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [GAIN_W-1:0]          i_cfg_data,    // feedback_gain
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic signed [SAMPLE_W-1:0] i_s_axis_tdata, // sample_in
    input  wire logic                       i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic signed [SAMPLE_W-1:0]      o_m_axis_tdata, // sample_out
    output logic                            o_m_axis_tlast
);

    localparam int PTR_W = (DELAY > 1) ? $clog2(DELAY) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUB  = 6'b000100,
        S_ABS  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state                     r_state;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_last;
    logic [PTR_W-1:0]           r_ptr;
    logic                       r_full;
    logic signed [SAMPLE_W-1:0] r_mem [DELAY];
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic [GAIN_W-1:0]          r_kshift;
    logic [2:0]                 r_mcnt;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_out_data;
    logic                       r_out_last;
    logic                       r_out_valid;

    logic                       w_accept;
    logic                       w_fin;
    logic signed [SAMPLE_W-1:0] w_old;
    logic signed [ACC_W-1:0]    w_abs;
    logic [DIVR_W-1:0]          w_divisor;
    logic                       w_div_done;
    logic [QUO_W-1:0]           w_quo;
    logic [SAMPLE_W-1:0]        w_sat;
    logic signed [SAMPLE_W-1:0] w_y;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fin           = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        w_old     = r_full ? r_rd_data : '0;
        w_abs     = r_acc[ACC_W-1] ? -r_acc : r_acc;
        w_divisor = DIVR_W'(r_gain) + DIVR_W'(1);
        w_sat     = w_quo[QUO_W-1] ? {1'b0, SAT_MAG} : {1'b0, w_quo[QUO_W-2:0]};
        w_y       = r_neg ? -$signed(w_sat) : $signed(w_sat);
    end

    fch_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_ABS),
        .i_dividend (MAG_W'(w_abs)),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= '0;
            r_ptr       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gain <= i_cfg_data;
            end
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mcnt == 3'd0) begin
                        r_state <= S_SUB;
                    end
                end
                S_SUB: r_state <= S_ABS;
                S_ABS: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_fin) begin
                        r_state <= S_IDLE;
                        if (r_ptr == PTR_W'(DELAY - 1)) begin
                            r_ptr  <= '0;
                            r_full <= 1'b1;
                        end else begin
                            r_ptr <= r_ptr + PTR_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x       <= i_s_axis_tdata;
            r_last    <= i_s_axis_tlast;
            r_rd_data <= r_mem[r_ptr];
            r_kshift  <= r_gain;
            r_mcnt    <= 3'd7;
            r_prod    <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod   <= (r_prod <<< 1)
                        + (r_kshift[GAIN_W-1] ? PROD_W'(w_old) : PROD_W'(0));
            r_kshift <= {r_kshift[GAIN_W-2:0], 1'b0};
            r_mcnt   <= r_mcnt - 3'd1;
        end
        if (r_state == S_SUB) begin
            r_acc <= ACC_W'(r_x) - ACC_W'(r_prod);
        end
        if (r_state == S_ABS) begin
            r_neg <= r_acc[ACC_W-1];
        end
        if (w_fin) begin
            r_mem[r_ptr] <= w_y;
            r_out_data   <= w_y;
            r_out_last   <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire
